// ===== design/dps_pkg.sv =====
// Shared types and constants for the dynamic priority scheduler.
// Used by every module of the scheduler; depends on nothing else.
package dps_pkg;

   localparam int NUM_TASKS_DEFAULT = 8;
   localparam int PRIO_W            = 16;
   localparam int TIME_W            = 16;
   localparam int CFG_W             = 8;
   localparam int ENTRY_IDX_W       = 3;
   localparam int SLICE_W           = 32;
   localparam int CSR_IDX_W         = 1;

   localparam logic signed [PRIO_W-1:0] PRIO_MAX    = 16'sh7FFF;
   localparam logic signed [PRIO_W-1:0] PRIO_MIN    = 16'sh8000;
   localparam logic signed [PRIO_W-1:0] PRIO_PARKED = 16'shFFFF;
   localparam logic [TIME_W-1:0]        TIME_MAX    = 16'hFFFF;

   localparam logic [CFG_W-1:0] AGING_STEP_RESET  = 8'd1;
   localparam logic [CFG_W-1:0] RUN_PENALTY_RESET = 8'd3;

   typedef enum logic [1:0] {
      ST_READY    = 2'd0,
      ST_BLOCKED  = 2'd1,
      ST_FINISHED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_UPDATE
   } fsm_state_type;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AGING_STEP  = 1'b0,
      CSR_RUN_PENALTY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [TIME_W-1:0]        remaining;
      logic [TIME_W-1:0]        used;
      logic [TIME_W-1:0]        runs_left;
      logic [TIME_W-1:0]        blocked_left;
   } entry_type;

   // Control from the sequencer to the table and the update unit.
   typedef struct packed {
      logic upd_en;
      logic is_tick;
      logic found;
      logic hit;
      logic first;
      logic last;
   } ctrl_type;

endpackage

// ===== design/dps_update_unit.sv =====
// Per-entry update logic: one saturating priority adder shared by aging and penalty.
// Depends on dps_pkg.
module dps_update_unit (
   input  dps_pkg::ctrl_type                     ctrl,
   input  dps_pkg::entry_type                    entry_old,
   input  dps_pkg::status_type                   status_old,
   input  logic signed [dps_pkg::PRIO_W-1:0]     saved_old,
   input  logic [dps_pkg::CFG_W-1:0]             aging_step,
   input  logic [dps_pkg::CFG_W-1:0]             run_penalty,
   input  logic signed [dps_pkg::PRIO_W-1:0]     load_priority,
   input  logic [dps_pkg::TIME_W-1:0]            load_need,
   input  logic [dps_pkg::TIME_W-1:0]            load_block_after,
   input  logic [dps_pkg::TIME_W-1:0]            load_block_length,
   output dps_pkg::entry_type                    entry_new,
   output dps_pkg::status_type                   status_new,
   output logic                                  saved_we,
   output logic signed [dps_pkg::PRIO_W-1:0]     saved_new,
   output logic                                  blocked_now
);

   localparam int SUM_W = dps_pkg::PRIO_W + 2;

   logic [SUM_W-1:0]                   operand;
   logic [SUM_W-1:0]                   sum;
   logic signed [dps_pkg::PRIO_W-1:0]  prio_sat;
   logic [dps_pkg::TIME_W-1:0]         remaining_dec;
   logic [dps_pkg::TIME_W-1:0]         runs_dec;
   logic [dps_pkg::TIME_W-1:0]         blocked_dec;

   // The chosen entry pays the penalty; other ready entries with work left gain the aging step.
   always_comb begin
      if (ctrl.hit) begin
         operand = -{{(SUM_W-dps_pkg::CFG_W){1'b0}}, run_penalty};
      end else begin
         operand = {{(SUM_W-dps_pkg::CFG_W){1'b0}}, aging_step};
      end
      sum = {{2{entry_old.prio[dps_pkg::PRIO_W-1]}}, entry_old.prio} + operand;
      if (!sum[SUM_W-1] && (sum[SUM_W-2:SUM_W-3] != 2'b00)) begin
         prio_sat = dps_pkg::PRIO_MAX;
      end else if (sum[SUM_W-1] && (sum[SUM_W-2:SUM_W-3] != 2'b11)) begin
         prio_sat = dps_pkg::PRIO_MIN;
      end else begin
         prio_sat = signed'(sum[dps_pkg::PRIO_W-1:0]);
      end
   end

   assign remaining_dec = (entry_old.remaining != '0) ? entry_old.remaining - 1'b1 : '0;
   assign runs_dec      = entry_old.runs_left - 1'b1;
   assign blocked_dec   = (entry_old.blocked_left != '0) ? entry_old.blocked_left - 1'b1 : '0;

   always_comb begin
      entry_new   = entry_old;
      status_new  = status_old;
      saved_we    = 1'b0;
      saved_new   = prio_sat;
      blocked_now = 1'b0;
      if (!ctrl.is_tick) begin
         if (ctrl.hit) begin
            entry_new.prio         = load_priority;
            entry_new.remaining    = load_need;
            entry_new.used         = '0;
            entry_new.runs_left    = load_block_after;
            entry_new.blocked_left = load_block_length;
            status_new = (load_need == '0) ? dps_pkg::ST_FINISHED : dps_pkg::ST_READY;
         end
      end else if (ctrl.hit) begin
         entry_new.prio      = prio_sat;
         entry_new.remaining = remaining_dec;
         if (entry_old.used != dps_pkg::TIME_MAX) begin
            entry_new.used = entry_old.used + 1'b1;
         end
         // Finishing takes precedence over blocking.
         if (remaining_dec == '0) begin
            status_new     = dps_pkg::ST_FINISHED;
            entry_new.prio = dps_pkg::PRIO_PARKED;
         end else if (entry_old.runs_left != '0) begin
            entry_new.runs_left = runs_dec;
            if (runs_dec == '0) begin
               status_new     = dps_pkg::ST_BLOCKED;
               entry_new.prio = dps_pkg::PRIO_PARKED;
               saved_we       = 1'b1;
               blocked_now    = 1'b1;
            end
         end
      end else begin
         case (status_old)
            dps_pkg::ST_READY: begin
               if (ctrl.found && (entry_old.remaining != '0)) begin
                  entry_new.prio = prio_sat;
               end
            end
            dps_pkg::ST_BLOCKED: begin
               entry_new.blocked_left = blocked_dec;
               if (blocked_dec == '0) begin
                  status_new     = dps_pkg::ST_READY;
                  entry_new.prio = saved_old;
               end
            end
            default: begin
               entry_new = entry_old;
            end
         endcase
      end
   end

endmodule

// ===== design/dps_sequencer.sv =====
// Sequencer: a tick walks the task table once to pick the winner, once more to update it;
// a load takes only the update pass. Holds the running maximum and the chosen index; depends on dps_pkg.
module dps_sequencer #(
   parameter int NUM_TASKS = dps_pkg::NUM_TASKS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 req_is_tick,
   input  logic [dps_pkg::ENTRY_IDX_W-1:0]      load_index,
   input  logic [$clog2(NUM_TASKS)-1:0]         scan_pointer,
   input  dps_pkg::status_type                  entry_status,
   input  logic signed [dps_pkg::PRIO_W-1:0]    entry_prio,
   output logic                                 busy,
   output logic [$clog2(NUM_TASKS)-1:0]         idx,
   output logic [$clog2(NUM_TASKS)-1:0]         chosen,
   output dps_pkg::ctrl_type                    ctrl
);

   localparam int IDX_W = $clog2(NUM_TASKS);
   localparam int CMP_W = IDX_W + dps_pkg::ENTRY_IDX_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TASKS - 1);

   dps_pkg::fsm_state_type           state_ff, state_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [IDX_W-1:0]                 cnt_ff, cnt_in;
   logic [IDX_W-1:0]                 chosen_ff, chosen_in;
   logic signed [dps_pkg::PRIO_W-1:0] best_ff, best_in;
   logic                             tick_ff, tick_in;
   logic                             found_ff, found_in;
   logic                             accept;
   logic                             take;
   logic [IDX_W-1:0]                 idx_wrap;

   assign accept   = start && (state_ff == dps_pkg::FSM_IDLE);
   assign idx_wrap = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
   // Shared comparator: strict greater keeps the first of equal priorities.
   assign take = (entry_status == dps_pkg::ST_READY) && (!found_ff || (entry_prio > best_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dps_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = req_is_tick ? dps_pkg::FSM_SCAN : dps_pkg::FSM_UPDATE;
            end
         end
         dps_pkg::FSM_SCAN: begin
            if (cnt_ff == IDX_LAST) begin
               state_in = dps_pkg::FSM_UPDATE;
            end
         end
         dps_pkg::FSM_UPDATE: begin
            if (idx_ff == IDX_LAST) begin
               state_in = dps_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = dps_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      chosen_in = chosen_ff;
      best_in   = best_ff;
      tick_in   = tick_ff;
      found_in  = found_ff;
      case (state_ff)
         dps_pkg::FSM_IDLE: begin
            if (accept) begin
               tick_in  = req_is_tick;
               found_in = 1'b0;
               cnt_in   = '0;
               idx_in   = req_is_tick ? scan_pointer : '0;
            end
         end
         dps_pkg::FSM_SCAN: begin
            if (take) begin
               found_in  = 1'b1;
               chosen_in = idx_ff;
               best_in   = entry_prio;
            end
            cnt_in = cnt_ff + 1'b1;
            idx_in = (cnt_ff == IDX_LAST) ? '0 : idx_wrap;
         end
         dps_pkg::FSM_UPDATE: begin
            idx_in = idx_wrap;
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dps_pkg::FSM_IDLE;
         tick_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      chosen_ff <= chosen_in;
      best_ff   <= best_in;
   end

   always_comb begin
      busy         = (state_ff != dps_pkg::FSM_IDLE);
      idx          = idx_ff;
      chosen       = chosen_ff;
      ctrl.upd_en  = (state_ff == dps_pkg::FSM_UPDATE);
      ctrl.is_tick = tick_ff;
      ctrl.found   = found_ff;
      if (tick_ff) begin
         ctrl.hit = found_ff && (idx_ff == chosen_ff);
      end else begin
         ctrl.hit = (CMP_W'(idx_ff) == CMP_W'(load_index));
      end
      ctrl.first = ctrl.upd_en && (idx_ff == '0);
      ctrl.last  = ctrl.upd_en && (idx_ff == IDX_LAST);
   end

endmodule

// ===== design/dynamic_priority_scheduler_core.sv =====
// Top level of the dynamic priority scheduler: task table, configuration and result registers.
// Depends on dps_pkg, dps_sequencer and dps_update_unit.
//
// Usage. An item is transferred on a rising edge with start high and busy low.
// req_type selects a load (writes entry req_entry_index; indexes at or beyond
// NUM_TASKS are dropped) or a scheduling tick. Exactly one result follows each
// item: rsp_strobe is high for one cycle and the rsp_ fields are valid only then.
// A load keeps busy high for one pass over the table that writes the addressed
// entry; a tick for one pass to find the ready entry of highest priority and one
// pass to update every entry. Each pass handles one entry per cycle through the
// shared priority adder and comparator. The strobe comes in the first cycle
// after busy falls, and a new start can be taken in that same cycle.
// The receiver cannot stall; it must take every result transfer as it comes.
// csr_ writes set aging_step (index 0) and run_penalty (index 1); they take effect
// at once. The user must make them while the block is idle; the block itself has no check.
// Reset marks every entry finished, clears the scan pointer and slice count,
// and restores aging_step to 1 and run_penalty to 3.
module dynamic_priority_scheduler_core #(
   parameter int NUM_TASKS = dps_pkg::NUM_TASKS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_type,
   input  logic [dps_pkg::ENTRY_IDX_W-1:0]      req_entry_index,
   input  logic signed [dps_pkg::PRIO_W-1:0]    req_start_priority,
   input  logic [dps_pkg::TIME_W-1:0]           req_need_time,
   input  logic [dps_pkg::TIME_W-1:0]           req_block_after,
   input  logic [dps_pkg::TIME_W-1:0]           req_block_length,
   output logic                                 rsp_strobe,
   output logic                                 rsp_ran_valid,
   output logic [dps_pkg::ENTRY_IDX_W-1:0]      rsp_ran_index,
   output logic [dps_pkg::SLICE_W-1:0]          rsp_slice_number,
   output logic [dps_pkg::TIME_W-1:0]           rsp_ran_used,
   output logic [dps_pkg::TIME_W-1:0]           rsp_ran_left,
   output logic                                 rsp_ran_blocked,
   output logic                                 rsp_all_finished,
   input  logic                                 csr_write_enable,
   input  logic [dps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dps_pkg::CFG_W-1:0]            csr_write_data
);

   localparam int IDX_W = $clog2(NUM_TASKS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TASKS - 1);

   dps_pkg::entry_type                 data_ff   [NUM_TASKS];
   dps_pkg::status_type                status_ff [NUM_TASKS];
   logic signed [dps_pkg::PRIO_W-1:0]  saved_ff  [NUM_TASKS];

   logic [dps_pkg::CFG_W-1:0]          aging_ff;
   logic [dps_pkg::CFG_W-1:0]          penalty_ff;
   logic [IDX_W-1:0]                   scan_ptr_ff;
   logic [dps_pkg::SLICE_W-1:0]        slice_ff;
   logic                               fin_acc_ff;

   logic [dps_pkg::ENTRY_IDX_W-1:0]    ld_index_ff;
   logic signed [dps_pkg::PRIO_W-1:0]  ld_prio_ff;
   logic [dps_pkg::TIME_W-1:0]         ld_need_ff;
   logic [dps_pkg::TIME_W-1:0]         ld_after_ff;
   logic [dps_pkg::TIME_W-1:0]         ld_length_ff;

   logic                               rsp_strobe_ff;
   logic                               rsp_ran_valid_ff;
   logic [dps_pkg::ENTRY_IDX_W-1:0]    rsp_ran_index_ff;
   logic [dps_pkg::SLICE_W-1:0]        rsp_slice_ff;
   logic [dps_pkg::TIME_W-1:0]         rsp_used_ff;
   logic [dps_pkg::TIME_W-1:0]         rsp_left_ff;
   logic                               rsp_blocked_ff;
   logic                               rsp_fin_ff;

   logic                               accept;
   logic [IDX_W-1:0]                   idx;
   logic [IDX_W-1:0]                   chosen;
   dps_pkg::ctrl_type                  ctrl;
   dps_pkg::entry_type                 entry_new;
   dps_pkg::status_type                status_new;
   logic                               saved_we;
   logic signed [dps_pkg::PRIO_W-1:0]  saved_new;
   logic                               blocked_now;
   logic                               fin_now;
   logic                               dispatch;

   assign accept = start && !busy;

   dps_sequencer #(
      .NUM_TASKS (NUM_TASKS)
   ) u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_is_tick  (req_type == dps_pkg::REQ_TICK),
      .load_index   (ld_index_ff),
      .scan_pointer (scan_ptr_ff),
      .entry_status (status_ff[idx]),
      .entry_prio   (data_ff[idx].prio),
      .busy         (busy),
      .idx          (idx),
      .chosen       (chosen),
      .ctrl         (ctrl)
   );

   dps_update_unit u_update_unit (
      .ctrl              (ctrl),
      .entry_old         (data_ff[idx]),
      .status_old        (status_ff[idx]),
      .saved_old         (saved_ff[idx]),
      .aging_step        (aging_ff),
      .run_penalty       (penalty_ff),
      .load_priority     (ld_prio_ff),
      .load_need         (ld_need_ff),
      .load_block_after  (ld_after_ff),
      .load_block_length (ld_length_ff),
      .entry_new         (entry_new),
      .status_new        (status_new),
      .saved_we          (saved_we),
      .saved_new         (saved_new),
      .blocked_now       (blocked_now)
   );

   // The all-finished flag is gathered entry by entry during the update pass.
   assign fin_now  = (ctrl.first || fin_acc_ff) && (status_new == dps_pkg::ST_FINISHED);
   assign dispatch = ctrl.is_tick && ctrl.found;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            status_ff[i] <= dps_pkg::ST_FINISHED;
         end
      end else if (ctrl.upd_en) begin
         status_ff[idx] <= status_new;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.upd_en) begin
         data_ff[idx] <= entry_new;
         if (saved_we) begin
            saved_ff[idx] <= saved_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aging_ff   <= dps_pkg::AGING_STEP_RESET;
         penalty_ff <= dps_pkg::RUN_PENALTY_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            dps_pkg::CSR_AGING_STEP:  aging_ff   <= csr_write_data;
            dps_pkg::CSR_RUN_PENALTY: penalty_ff <= csr_write_data;
            default: begin
               aging_ff <= aging_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ld_index_ff  <= req_entry_index;
         ld_prio_ff   <= req_start_priority;
         ld_need_ff   <= req_need_time;
         ld_after_ff  <= req_block_after;
         ld_length_ff <= req_block_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         scan_ptr_ff   <= '0;
         slice_ff      <= '0;
         fin_acc_ff    <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.last;
         if (ctrl.upd_en) begin
            fin_acc_ff <= fin_now;
         end
         if (ctrl.last && dispatch) begin
            slice_ff    <= slice_ff + 1'b1;
            scan_ptr_ff <= (chosen == IDX_LAST) ? '0 : chosen + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.upd_en && ctrl.is_tick && ctrl.hit) begin
         rsp_used_ff    <= entry_new.used;
         rsp_left_ff    <= entry_new.remaining;
         rsp_blocked_ff <= blocked_now;
      end
      if (ctrl.last) begin
         rsp_fin_ff <= fin_now;
         if (dispatch) begin
            rsp_ran_valid_ff <= 1'b1;
            rsp_ran_index_ff <= dps_pkg::ENTRY_IDX_W'(chosen);
            rsp_slice_ff     <= slice_ff + 1'b1;
         end else begin
            rsp_ran_valid_ff <= 1'b0;
            rsp_ran_index_ff <= '0;
            rsp_slice_ff     <= '0;
            rsp_used_ff      <= '0;
            rsp_left_ff      <= '0;
            rsp_blocked_ff   <= 1'b0;
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_ran_valid    = rsp_ran_valid_ff;
   assign rsp_ran_index    = rsp_ran_index_ff;
   assign rsp_slice_number = rsp_slice_ff;
   assign rsp_ran_used     = rsp_used_ff;
   assign rsp_ran_left     = rsp_left_ff;
   assign rsp_ran_blocked  = rsp_blocked_ff;
   assign rsp_all_finished = rsp_fin_ff;

   // A result transfer always closes a busy period.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a preceding busy period");

   // One result per item: the strobe is never held high.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // An entry only blocks when it ran and still has work left.
   a_blocked_has_work: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_ran_blocked) |-> (rsp_ran_valid && (rsp_ran_left != '0)))
      else $error("blocked report without a dispatched unfinished entry");

   // The update pass always ends the busy period on the following edge.
   a_last_ends_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.last |=> (!busy && rsp_strobe))
      else $error("update pass ended without releasing busy");

endmodule
